// ===== design/spc_pkg.sv =====
package spc_pkg;

  localparam int STORED_BYTES = 6;
  localparam int FRAC_BITS    = 8;

  localparam int BYTE_W = 8;
  localparam int SUM_W  = 16;
  localparam int CNT_W  = 6;
  localparam int OFF_W  = 17;
  localparam int ANG_W  = 19;
  localparam int RAW_W  = 16;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET   = 2'd2;

  localparam logic signed [OFF_W-1:0] ROLL_OFFSET_RST  = -17'sd256;
  localparam logic signed [OFF_W-1:0] PITCH_OFFSET_RST = -17'sd256;
  localparam logic signed [OFF_W-1:0] YAW_OFFSET_RST   = 17'sd13824;

  localparam logic [BYTE_W-1:0] HDR_S = 8'h73;
  localparam logic [BYTE_W-1:0] HDR_N = 8'h6E;
  localparam logic [BYTE_W-1:0] HDR_P = 8'h70;
  localparam logic [SUM_W-1:0]  HDR_SUM = SUM_W'(HDR_S) + SUM_W'(HDR_N) + SUM_W'(HDR_P);

  localparam int TYPE_HAS_DATA_BIT = 7;
  localparam int TYPE_BATCH_BIT    = 6;
  localparam logic [CNT_W-1:0] LEN_SINGLE = 6'd4;

  // Scaling by 360/32768 is done as mag * 45 * 2^FRAC_BITS, rounded, shifted by 12.
  localparam int SCALE_SHIFT = 12;
  localparam int SCALE_W     = 6 + FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(45 * (1 << FRAC_BITS));
  localparam int PROD_W      = RAW_W + SCALE_W;
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1 << (SCALE_SHIFT - 1));
  localparam int MAG_W       = PROD_W - SCALE_SHIFT;
  localparam int ACC_W       = (MAG_W + 2 > 20) ? MAG_W + 2 : 20;

  localparam logic signed [ACC_W-1:0] ANG_MAX = ACC_W'(262143);
  localparam logic signed [ACC_W-1:0] ANG_MIN = -(ACC_W'(262144));

  typedef enum logic [2:0] {
    PH_HUNT_S  = 3'd0,
    PH_HUNT_N  = 3'd1,
    PH_HUNT_P  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_ADDR    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SUM_HI  = 3'd6,
    PH_SUM_LO  = 3'd7
  } phase_t;

  typedef logic [STORED_BYTES-1:0][BYTE_W-1:0] store_t;

  typedef struct packed {
    logic done;
    logic good;
  } evt_t;

endpackage

// ===== design/spc_parser.sv =====
module spc_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [spc_pkg::BYTE_W-1:0]   rx_byte,
  output spc_pkg::evt_t                evt,
  output spc_pkg::store_t              store
);

  spc_pkg::phase_t                    phase_r, phase_nxt;
  logic [spc_pkg::CNT_W-1:0]          len_r, len_nxt;
  logic [spc_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [spc_pkg::CNT_W-1:0]          cnt_plus;
  logic [spc_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic [spc_pkg::BYTE_W-1:0]         hi_r, hi_nxt;
  spc_pkg::store_t                    store_r, store_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spc_pkg::PH_HUNT_S;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      hi_r    <= '0;
      store_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      store_r <= store_nxt;
    end
  end

  assign cnt_plus = cnt_r + spc_pkg::CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    store_nxt = store_r;
    evt       = '0;
    case (phase_r)
      spc_pkg::PH_HUNT_S: begin
        phase_nxt = (rx_byte == spc_pkg::HDR_S) ? spc_pkg::PH_HUNT_N : spc_pkg::PH_HUNT_S;
      end
      spc_pkg::PH_HUNT_N: begin
        phase_nxt = (rx_byte == spc_pkg::HDR_N) ? spc_pkg::PH_HUNT_P : spc_pkg::PH_HUNT_S;
      end
      spc_pkg::PH_HUNT_P: begin
        if (rx_byte == spc_pkg::HDR_P) begin
          phase_nxt = spc_pkg::PH_TYPE;
          sum_nxt   = spc_pkg::HDR_SUM;
        end else begin
          phase_nxt = spc_pkg::PH_HUNT_S;
        end
      end
      spc_pkg::PH_TYPE: begin
        sum_nxt = sum_r + spc_pkg::SUM_W'(rx_byte);
        if (rx_byte[spc_pkg::TYPE_HAS_DATA_BIT]) begin
          len_nxt = rx_byte[spc_pkg::TYPE_BATCH_BIT] ? {rx_byte[5:2], 2'b00}
                                                     : spc_pkg::LEN_SINGLE;
        end else begin
          len_nxt = '0;
        end
        phase_nxt = spc_pkg::PH_ADDR;
      end
      spc_pkg::PH_ADDR: begin
        sum_nxt   = sum_r + spc_pkg::SUM_W'(rx_byte);
        cnt_nxt   = '0;
        phase_nxt = (len_r == '0) ? spc_pkg::PH_SUM_HI : spc_pkg::PH_PAYLOAD;
      end
      spc_pkg::PH_PAYLOAD: begin
        for (int i = 0; i < spc_pkg::STORED_BYTES; i++) begin
          if (cnt_r == spc_pkg::CNT_W'(i)) begin
            store_nxt[i] = rx_byte;
          end
        end
        sum_nxt = sum_r + spc_pkg::SUM_W'(rx_byte);
        cnt_nxt = cnt_plus;
        if (cnt_plus >= len_r) begin
          phase_nxt = spc_pkg::PH_SUM_HI;
        end
      end
      spc_pkg::PH_SUM_HI: begin
        hi_nxt    = rx_byte;
        phase_nxt = spc_pkg::PH_SUM_LO;
      end
      spc_pkg::PH_SUM_LO: begin
        evt.done  = 1'b1;
        evt.good  = ({hi_r, rx_byte} == sum_r);
        phase_nxt = spc_pkg::PH_HUNT_S;
      end
      default: begin
        phase_nxt = spc_pkg::PH_HUNT_S;
      end
    endcase
  end

  assign store = store_r;

endmodule

// ===== design/spc_angle_conv.sv =====
module spc_angle_conv (
  input  logic [spc_pkg::BYTE_W-1:0]        raw_hi,
  input  logic [spc_pkg::BYTE_W-1:0]        raw_lo,
  input  logic signed [spc_pkg::OFF_W-1:0]  offset,
  output logic signed [spc_pkg::ANG_W-1:0]  angle
);

  logic [spc_pkg::RAW_W-1:0]         raw;
  logic                              neg;
  logic [spc_pkg::RAW_W-1:0]         mag;
  logic [spc_pkg::PROD_W-1:0]        prod;
  logic [spc_pkg::PROD_W-1:0]        prod_rnd;
  logic [spc_pkg::MAG_W-1:0]         mag_q;
  logic signed [spc_pkg::ACC_W-1:0]  mag_s;
  logic signed [spc_pkg::ACC_W-1:0]  acc;

  assign raw      = {raw_hi, raw_lo};
  assign neg      = raw[spc_pkg::RAW_W-1];
  assign mag      = neg ? (~raw + spc_pkg::RAW_W'(1)) : raw;
  assign prod     = spc_pkg::PROD_W'(mag) * spc_pkg::PROD_W'(spc_pkg::SCALE_MUL);
  assign prod_rnd = prod + spc_pkg::ROUND_ADD;
  assign mag_q    = prod_rnd[spc_pkg::PROD_W-1:spc_pkg::SCALE_SHIFT];
  assign mag_s    = signed'(spc_pkg::ACC_W'(mag_q));
  assign acc      = (neg ? -mag_s : mag_s) + spc_pkg::ACC_W'(offset);

  always_comb begin
    if (acc > spc_pkg::ANG_MAX) begin
      angle = spc_pkg::ANG_W'(spc_pkg::ANG_MAX);
    end else if (acc < spc_pkg::ANG_MIN) begin
      angle = spc_pkg::ANG_W'(spc_pkg::ANG_MIN);
    end else begin
      angle = acc[spc_pkg::ANG_W-1:0];
    end
  end

endmodule

// ===== design/sensor_packet_parser_checksum_unit.sv =====
// Sensor packet parser: takes one received link byte per item and returns one result per
// byte. It finds the "snp" header, then the type byte, address byte, payload (0, 4 or up
// to 60 bytes) and a 16-bit checksum sent high byte first. On the last checksum byte the
// result shows packet_done, and checksum_good when the 16-bit wrapping sum of header,
// type, address and payload matched; in that case the first six payload bytes become
// roll, pitch and yaw in degrees with 8 fractional bits, plus the configured offsets,
// and are held. Every result carries the held angles. One byte is accepted every clock
// cycle while the output is not stalled; an item passes an input register and the parse
// and angle logic into the output register, and out_ready low stalls the input only
// once both registers are full. The user must write offsets through the cfg port only
// while no item is in flight; the block itself does not enforce this.
module sensor_packet_parser_checksum_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [spc_pkg::BYTE_W-1:0]            in_rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_packet_done,
  output logic                                  out_checksum_good,
  output logic signed [spc_pkg::ANG_W-1:0]      out_roll_deg_q8,
  output logic signed [spc_pkg::ANG_W-1:0]      out_pitch_deg_q8,
  output logic signed [spc_pkg::ANG_W-1:0]      out_yaw_deg_q8,
  input  logic                                  cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [spc_pkg::OFF_W-1:0]             cfg_data
);

  logic signed [spc_pkg::OFF_W-1:0]  roll_off_r, pitch_off_r, yaw_off_r;
  logic                              s1_valid_r;
  logic [spc_pkg::BYTE_W-1:0]        s1_byte_r;
  logic                              out_valid_r;
  logic                              out_done_r, out_good_r;
  logic signed [spc_pkg::ANG_W-1:0]  roll_r, pitch_r, yaw_r;
  logic                              adv;
  logic                              in_acc;
  spc_pkg::evt_t                     evt;
  spc_pkg::store_t                   store;
  logic signed [spc_pkg::ANG_W-1:0]  roll_conv, pitch_conv, yaw_conv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_off_r  <= spc_pkg::ROLL_OFFSET_RST;
      pitch_off_r <= spc_pkg::PITCH_OFFSET_RST;
      yaw_off_r   <= spc_pkg::YAW_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spc_pkg::CFG_ROLL_OFFSET:  roll_off_r  <= cfg_data;
        spc_pkg::CFG_PITCH_OFFSET: pitch_off_r <= cfg_data;
        spc_pkg::CFG_YAW_OFFSET:   yaw_off_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  spc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (s1_byte_r),
    .evt     (evt),
    .store   (store)
  );

  spc_angle_conv u_roll (
    .raw_hi (store[0]),
    .raw_lo (store[1]),
    .offset (roll_off_r),
    .angle  (roll_conv)
  );

  spc_angle_conv u_pitch (
    .raw_hi (store[2]),
    .raw_lo (store[3]),
    .offset (pitch_off_r),
    .angle  (pitch_conv)
  );

  spc_angle_conv u_yaw (
    .raw_hi (store[4]),
    .raw_lo (store[5]),
    .offset (yaw_off_r),
    .angle  (yaw_conv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_good_r  <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        out_done_r  <= evt.done;
        out_good_r  <= evt.good;
        if (evt.good) begin
          roll_r  <= roll_conv;
          pitch_r <= pitch_conv;
          yaw_r   <= yaw_conv;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_done   = out_done_r;
  assign out_checksum_good = out_good_r;
  assign out_roll_deg_q8   = roll_r;
  assign out_pitch_deg_q8  = pitch_r;
  assign out_yaw_deg_q8    = yaw_r;

endmodule

// ===== design/spc_checker.sv =====
module spc_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_ready,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  out_packet_done,
  input  logic                                  out_checksum_good,
  input  logic signed [spc_pkg::ANG_W-1:0]      out_roll_deg_q8,
  input  logic signed [spc_pkg::ANG_W-1:0]      out_pitch_deg_q8,
  input  logic signed [spc_pkg::ANG_W-1:0]      out_yaw_deg_q8
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_packet_done)
      && $stable(out_checksum_good) && $stable(out_roll_deg_q8)
      && $stable(out_pitch_deg_q8) && $stable(out_yaw_deg_q8))
    else $error("Stalled result changed.");

  a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_good |-> out_packet_done)
    else $error("Checksum good without packet end.");

  a_no_back_to_back_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_packet_done |=> !(out_valid && out_packet_done))
    else $error("Two packet ends in consecutive results.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while output can move.");

  a_angles_need_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && !out_checksum_good
      |-> $stable(out_roll_deg_q8) && $stable(out_pitch_deg_q8)
        && $stable(out_yaw_deg_q8))
    else $error("Held angles changed without a good packet.");

endmodule

bind sensor_packet_parser_checksum_unit spc_checker u_spc_checker (.*);
